// ----- hdl/rgb2yuv_pkg.sv -----
// Shared types, constants and helpers for the RGB to planar YUV 4:2:0 converter.
package rgb2yuv_pkg;

  localparam int unsigned MAX_WIDTH    = 4096;
  localparam int unsigned MAX_HEIGHT   = 4096;

  localparam int unsigned SIZE_W       = 13;
  localparam int unsigned COL_W        = $clog2(MAX_WIDTH);
  localparam int unsigned LINE_W       = $clog2(MAX_HEIGHT);
  localparam int unsigned LUMA_IDX_W   = 24;
  localparam int unsigned CHROMA_IDX_W = 22;
  localparam int unsigned PLANE_W      = 25;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned PIX_W        = 24;
  localparam int unsigned OUT_DATA_W   = 104;

  localparam int unsigned FIFO_DEPTH   = 2;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  typedef logic [SIZE_W-1:0] size_t;

  localparam size_t WIDTH_RESET  = SIZE_W'(1280);
  localparam size_t HEIGHT_RESET = SIZE_W'(720);
  localparam size_t MIN_SIZE     = SIZE_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  // One classified pixel, handed from the front end to the datapath.
  typedef struct packed {
    logic [7:0]              red;
    logic [7:0]              green;
    logic [7:0]              blue;
    logic                    chroma;
    logic                    frame_last;
    logic [LUMA_IDX_W-1:0]   luma_idx;
    logic [CHROMA_IDX_W-1:0] chroma_idx;
  } pix_job_t;

  function automatic size_t clamp_size(size_t v, size_t maxv);
    size_t r;
    if (v < MIN_SIZE) begin
      r = MIN_SIZE;
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/rgb2yuv_front.sv -----
// Front end: accepts pixels and tracks raster position, luma and chroma indexes.
module rgb2yuv_front import rgb2yuv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  input  logic [PIX_W-1:0] s_tdata_i,
  input  logic             q_ready_i,
  input  size_t            width_i,
  input  size_t            height_i,
  output logic             push_o,
  output pix_job_t         job_o
);

  logic [COL_W-1:0]        col_q, col_d;
  logic [LINE_W-1:0]       line_q, line_d;
  logic [LUMA_IDX_W-1:0]   luma_idx_q, luma_idx_d;
  logic [CHROMA_IDX_W-1:0] chroma_idx_q, chroma_idx_d;

  logic accept;
  logic chroma;
  logic line_end;
  logic frame_end;

  assign accept    = s_tvalid_i & q_ready_i;
  assign chroma    = ~line_q[0] & ~col_q[0];
  assign line_end  = (SIZE_W'(col_q) + SIZE_W'(1)) >= width_i;
  assign frame_end = line_end && ((SIZE_W'(line_q) + SIZE_W'(1)) >= height_i);

  always_comb begin
    col_d        = col_q;
    line_d       = line_q;
    luma_idx_d   = luma_idx_q;
    chroma_idx_d = chroma_idx_q;
    if (accept) begin
      if (frame_end) begin
        col_d        = '0;
        line_d       = '0;
        luma_idx_d   = '0;
        chroma_idx_d = '0;
      end else begin
        luma_idx_d = luma_idx_q + LUMA_IDX_W'(1);
        if (chroma) begin
          chroma_idx_d = chroma_idx_q + CHROMA_IDX_W'(1);
        end
        if (line_end) begin
          col_d  = '0;
          line_d = line_q + LINE_W'(1);
        end else begin
          col_d  = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      line_q       <= '0;
      luma_idx_q   <= '0;
      chroma_idx_q <= '0;
    end else begin
      col_q        <= col_d;
      line_q       <= line_d;
      luma_idx_q   <= luma_idx_d;
      chroma_idx_q <= chroma_idx_d;
    end
  end

  assign push_o           = accept;
  assign job_o.red        = s_tdata_i[7:0];
  assign job_o.green      = s_tdata_i[15:8];
  assign job_o.blue       = s_tdata_i[23:16];
  assign job_o.chroma     = chroma;
  assign job_o.frame_last = frame_end;
  assign job_o.luma_idx   = luma_idx_q;
  assign job_o.chroma_idx = chroma_idx_q;

endmodule

// ----- hdl/rgb2yuv_fifo.sv -----
// Two-entry queue between the front end and the color datapath.
module rgb2yuv_fifo import rgb2yuv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pix_job_t job_i,
  output logic     ready_o,
  input  logic     pop_i,
  output logic     valid_o,
  output pix_job_t job_o
);

  pix_job_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0]   count_q;

  assign ready_o = count_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

// ----- hdl/rgb2yuv_back.sv -----
// Color datapath: matrix sums, then sample values and plane addresses.
module rgb2yuv_back import rgb2yuv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  pix_job_t              q_job_i,
  output logic                  pop_o,
  input  logic [PLANE_W-1:0]    plane_i,
  input  logic [PLANE_W-1:0]    vbase_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic                  m_tuser_o,
  output logic                  m_tlast_o
);

  // stage 1: products and sums
  logic                    s1_valid_q;
  logic [15:0]             y_sum_q;
  logic signed [15:0]      u_sum_q, v_sum_q;
  logic                    s1_chroma_q, s1_last_q;
  logic [LUMA_IDX_W-1:0]   s1_luma_idx_q;
  logic [CHROMA_IDX_W-1:0] s1_chroma_idx_q;

  // stage 2: output beat
  logic                    out_valid_q;
  logic [OUT_DATA_W-1:0]   out_data_q;
  logic                    out_user_q, out_last_q;

  logic s1_adv, out_adv;
  logic signed [17:0] r_s, g_s, b_s;
  logic signed [17:0] y_full, u_full, v_full;

  logic [7:0]         y_val, cb_val, cr_val;
  logic [PLANE_W-1:0] cb_addr, cr_addr;

  assign out_adv = !out_valid_q || m_tready_i;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign pop_o   = q_valid_i && s1_adv;

  assign r_s = signed'({10'b0, q_job_i.red});
  assign g_s = signed'({10'b0, q_job_i.green});
  assign b_s = signed'({10'b0, q_job_i.blue});

  assign y_full = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s;
  assign u_full = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s;
  assign v_full = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      y_sum_q         <= y_full[15:0];
      u_sum_q         <= u_full[15:0];
      v_sum_q         <= v_full[15:0];
      s1_chroma_q     <= q_job_i.chroma;
      s1_last_q       <= q_job_i.frame_last;
      s1_luma_idx_q   <= q_job_i.luma_idx;
      s1_chroma_idx_q <= q_job_i.chroma_idx;
    end
  end

  // floor(sum/256)+128 is the high byte with its top bit flipped
  assign y_val   = y_sum_q[15:8] + 8'd16;
  assign cb_val  = s1_chroma_q ? {~u_sum_q[15], u_sum_q[14:8]} : 8'd0;
  assign cr_val  = s1_chroma_q ? {~v_sum_q[15], v_sum_q[14:8]} : 8'd0;
  assign cb_addr = s1_chroma_q ? plane_i + PLANE_W'(s1_chroma_idx_q) : '0;
  assign cr_addr = s1_chroma_q ? vbase_i + PLANE_W'(s1_chroma_idx_q) : '0;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_adv) begin
      out_data_q <= {6'b0, cr_addr, cr_val, cb_addr, cb_val, s1_luma_idx_q, y_val};
      out_user_q <= s1_chroma_q;
      out_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= q_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_tready_i) |=> s1_valid_q)
    else $error("stage 1 beat dropped under stall");

  a_no_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o) |-> (m_tdata_o[97:32] == '0))
    else $error("chroma fields not cleared");

endmodule

// ----- hdl/rgb_to_yuv420_planar_stream.sv -----
// Top level of the RGB to planar YUV 4:2:0 (BT.601 studio range) converter.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata[23:0]: red, green, blue
// m_*       out  m_tvalid/m_tready    tdata: Y, Y addr, U, U addr, V, V addr;
//                                     tuser: chroma_valid; tlast: frame_last
// cfg_*     in   cfg_valid/cfg_ready  index 0 = frame_width, 1 = frame_height
//
// One pixel per clock sustained while m_tready stays high; an accepted beat
// passes the queue, the matrix sum stage and the output register.
// The 13x13 plane-size multiply runs off the size registers; its product is
// registered into plane_q, and vbase_q is registered from plane_q, for the address adders.
// Reset clears counters and pipeline valids; sizes return to 1280x720.
// Output stalls back up through a two-entry queue; s_tready drops only when it
// is full.
module rgb_to_yuv420_planar_stream import rgb2yuv_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [PIX_W-1:0]      s_tdata_i,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // [7:0] luma_value, [31:8] luma_address, [39:32] cb_value, [64:40] cb_address,
  // [72:65] cr_value, [97:73] cr_address, [103:98] zero
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  output logic                  m_tuser_o,   // [0] chroma_valid
  output logic                  m_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  size_t                 cfg_data_i
);

  size_t width_q, height_q;
  size_t width_eff, height_eff;
  logic [PLANE_W-1:0] plane_q, vbase_q;
  logic [2*SIZE_W-1:0] plane_full;

  logic     push, pop, q_ready, q_valid;
  pix_job_t push_job, pop_job;

  // Size registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = clamp_size(width_q, SIZE_W'(MAX_WIDTH));
  assign height_eff = clamp_size(height_q, SIZE_W'(MAX_HEIGHT));
  assign plane_full = (2*SIZE_W)'(width_eff) * (2*SIZE_W)'(height_eff);

  // U plane base = W*H, V plane base = W*H + W*H/4 (rounded down)
  always_ff @(posedge clk_i) begin
    plane_q <= plane_full[PLANE_W-1:0];
    vbase_q <= plane_q + (plane_q >> 2);
  end

  assign s_tready_o = q_ready;

  rgb2yuv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tdata_i  (s_tdata_i),
    .q_ready_i  (q_ready),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .push_o     (push),
    .job_o      (push_job)
  );

  rgb2yuv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (pop_job)
  );

  rgb2yuv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (pop_job),
    .pop_o      (pop),
    .plane_i    (plane_q),
    .vbase_i    (vbase_q),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule
